@@ rtl/core/ptm_pkg.sv @@
// ptm_pkg: shared types, codes and entry-format helpers for the page table mapper
// used by every module under rtl/core; depends on nothing
`default_nettype none

package ptm_pkg;

   // sizes fixed by the entry and item formats
   localparam int POOL_PAGES_DEFAULT = 64;
   localparam int SLOTS              = 512;
   localparam int SLOT_W             = 9;
   localparam int ENTRY_W            = 64;
   localparam int MEM_W              = ENTRY_W + 1;
   localparam int FRAME_W            = 40;
   localparam int USED_W             = 7;

   // command codes
   localparam logic [1:0] CMD_MAP_4K = 2'd0;
   localparam logic [1:0] CMD_MAP_2M = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_POOL_FULL = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE   = 2'd2;

   // walk levels, root first
   localparam logic [1:0] LVL_1 = 2'd0;
   localparam logic [1:0] LVL_2 = 2'd1;
   localparam logic [1:0] LVL_3 = 2'd2;
   localparam logic [1:0] LVL_4 = 2'd3;

   // entry formats
   localparam logic [ENTRY_W-1:0] ADDR_MASK   = 64'h000F_FFFF_FFFF_F000;
   localparam logic [ENTRY_W-1:0] LARGE_MASK  = 64'h000F_FFFF_FFE0_0000;
   localparam logic [ENTRY_W-1:0] FLAGS_TABLE = 64'h0000_0000_0000_0003;
   localparam logic [ENTRY_W-1:0] FLAGS_LARGE = 64'h0000_0000_0000_0083;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [51:0] phys_addr;
      logic [47:0] virt_addr;
      logic [5:0]  read_table;
      logic [8:0]  read_slot;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [63:0]       read_data;
      logic [USED_W-1:0] tables_used;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       clear_wr;
      logic       load_item;
      logic       follow;
      logic       alloc;
      logic       leaf_wr;
      logic       take_data;
      logic       load_rsp;
      logic [1:0] level;
      logic [1:0] status;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic present;
      logic outside;
      logic pool_full;
   } dp_stat_type;

   // entry pointing at a table page frame
   function automatic logic [ENTRY_W-1:0] table_entry(input logic [FRAME_W-1:0] frame);
      return {12'h000, frame, 12'h000} | FLAGS_TABLE;
   endfunction

   // 4 KiB leaf entry
   function automatic logic [ENTRY_W-1:0] leaf_4k(input logic [51:0] pa);
      return ({12'h000, pa} & ADDR_MASK) | FLAGS_TABLE;
   endfunction

   // 2 MiB leaf entry
   function automatic logic [ENTRY_W-1:0] leaf_2m(input logic [51:0] pa);
      return ({12'h000, pa} & LARGE_MASK) | FLAGS_LARGE;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/ptm_ram.sv @@
// ptm_ram: generic simple dual-port memory, one write and one registered read per cycle
// defaults from ptm_pkg
`default_nettype none

module ptm_ram #(
   parameter int  WIDTH  = ptm_pkg::MEM_W,
   parameter int  DEPTH  = ptm_pkg::POOL_PAGES_DEFAULT * ptm_pkg::SLOTS,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/ptm_ctrl.sv @@
// ptm_ctrl: sequencer for clear pass, table walk, leaf write and result hand-off
// depends on ptm_pkg
`default_nettype none

module ptm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_cmd,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  ptm_pkg::dp_stat_type  stat,
   output ptm_pkg::ctl_cmd_type  cmd
);

   import ptm_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_CHECK,
      ST_LEAF,
      ST_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] level_ff, level_in;
   logic [1:0] op_ff, op_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] last_level;

   // last walked level before the leaf
   assign last_level = (op_ff == CMD_MAP_2M) ? LVL_2 : LVL_3;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.level    = level_ff;
      cmd.status   = status_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               op_in         = req_cmd;
               level_in      = LVL_1;
               status_in     = STATUS_DONE;
               if (req_cmd inside {CMD_MAP_4K, CMD_MAP_2M, CMD_READ}) begin
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (op_ff == CMD_READ) begin
               cmd.take_data = 1'b1;
               state_in      = ST_FINISH;
            end else if (stat.present && stat.outside) begin
               status_in = STATUS_OUTSIDE;
               state_in  = ST_FINISH;
            end else if (!stat.present && stat.pool_full) begin
               status_in = STATUS_POOL_FULL;
               state_in  = ST_FINISH;
            end else begin
               // follow the entry or hang a fresh page under it
               cmd.follow = stat.present;
               cmd.alloc  = !stat.present;
               level_in   = level_ff + 2'd1;
               state_in   = (level_ff == last_level) ? ST_LEAF : ST_LOOKUP;
            end
         end
         ST_LEAF: begin
            cmd.leaf_wr = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         level_ff     <= LVL_1;
         op_ff        <= CMD_MAP_4K;
         status_ff    <= STATUS_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         op_ff        <= op_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ rtl/core/ptm_datapath.sv @@
// ptm_datapath: table memory, walk registers, entry formatting and result register
// depends on ptm_pkg and ptm_ram
`default_nettype none

module ptm_datapath #(
   parameter int POOL_PAGES = ptm_pkg::POOL_PAGES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ptm_pkg::req_type              req_data,
   input  logic                          csr_wr,
   input  logic [ptm_pkg::FRAME_W-1:0]   csr_data,
   input  ptm_pkg::ctl_cmd_type          cmd,
   output ptm_pkg::dp_stat_type          stat,
   output ptm_pkg::rsp_type              rsp_data
);

   import ptm_pkg::*;

   localparam int PAGE_W = $clog2(POOL_PAGES);
   localparam int CNT_W  = $clog2(POOL_PAGES + 1);
   localparam int DEPTH  = POOL_PAGES * SLOTS;
   localparam int ADDR_W = PAGE_W + SLOT_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   req_type             item_ff, item_in;
   logic [FRAME_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]    next_free_ff, next_free_in;
   logic [PAGE_W-1:0]   cur_ff, cur_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [ENTRY_W-1:0]  data_ff, data_in;
   rsp_type             rsp_ff, rsp_in;

   logic [SLOT_W-1:0]   lvl_idx;
   logic [SLOT_W-1:0]   slot_idx;
   logic [ADDR_W-1:0]   walk_addr;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [MEM_W-1:0]    mem_wdata;
   logic [MEM_W-1:0]    mem_rdata;
   logic                page_live;
   logic [ENTRY_W-1:0]  entry_eff;
   logic [FRAME_W-1:0]  off;
   logic                tag_wr;
   logic [ENTRY_W-1:0]  leaf_entry;

   // per-level 9-bit index from the virtual address
   always_comb begin
      case (cmd.level)
         LVL_1:   lvl_idx = item_ff.virt_addr[47:39];
         LVL_2:   lvl_idx = item_ff.virt_addr[38:30];
         LVL_3:   lvl_idx = item_ff.virt_addr[29:21];
         default: lvl_idx = item_ff.virt_addr[20:12];
      endcase
   end

   assign slot_idx  = (item_ff.cmd == CMD_READ) ? item_ff.read_slot : lvl_idx;
   assign walk_addr = {cur_ff, slot_idx};

   // entries carry a tag bit: set when written while the page was in use;
   // an untagged entry of an in-use page was written before the page was
   // handed out and reads as zero, which stands in for clearing the page
   assign page_live = CNT_W'(cur_ff) < next_free_ff;
   assign entry_eff = (page_live && !mem_rdata[ENTRY_W]) ? '0 : mem_rdata[ENTRY_W-1:0];
   assign off       = entry_eff[51:12] - base_ff;

   assign stat.clear_last = (clr_addr_ff == LAST_ADDR);
   assign stat.present    = entry_eff[0];
   assign stat.outside    = (off >= FRAME_W'(POOL_PAGES));
   assign stat.pool_full  = (next_free_ff == CNT_W'(POOL_PAGES));

   // a fresh page taken now is in use by the time the entry lands
   assign tag_wr = cmd.alloc ? (CNT_W'(cur_ff) <= next_free_ff) : page_live;
   assign leaf_entry = (item_ff.cmd == CMD_MAP_2M) ? leaf_2m(item_ff.phys_addr)
                                                   : leaf_4k(item_ff.phys_addr);

   // memory write selection
   always_comb begin
      mem_we    = cmd.clear_wr || cmd.alloc || cmd.leaf_wr;
      mem_waddr = walk_addr;
      mem_wdata = {tag_wr, leaf_entry};
      if (cmd.clear_wr) begin
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (cmd.alloc) begin
         mem_wdata = {tag_wr, table_entry(base_ff + FRAME_W'(next_free_ff))};
      end
   end

   ptm_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (walk_addr),
      .rd_data (mem_rdata)
   );

   // next values of the walk and result registers
   always_comb begin
      item_in      = item_ff;
      base_in      = csr_wr ? csr_data : base_ff;
      next_free_in = next_free_ff;
      cur_in       = cur_ff;
      clr_addr_in  = cmd.clear_wr ? ADDR_W'(clr_addr_ff + 1'b1) : clr_addr_ff;
      rd_ok_in     = rd_ok_ff;
      data_in      = data_ff;
      rsp_in       = rsp_ff;
      if (cmd.load_item) begin
         item_in  = req_data;
         rd_ok_in = int'(req_data.read_table) < POOL_PAGES;
         data_in  = '0;
         cur_in   = (req_data.cmd == CMD_READ) ? PAGE_W'(req_data.read_table) : '0;
      end
      if (cmd.follow) begin
         cur_in = off[PAGE_W-1:0];
      end
      if (cmd.alloc) begin
         cur_in       = next_free_ff[PAGE_W-1:0];
         next_free_in = CNT_W'(next_free_ff + 1'b1);
      end
      if (cmd.take_data) begin
         data_in = rd_ok_ff ? entry_eff : '0;
      end
      if (cmd.load_rsp) begin
         rsp_in.status      = cmd.status;
         rsp_in.read_data   = data_ff;
         rsp_in.tables_used = USED_W'(next_free_ff);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_free_ff <= CNT_W'(1);
         clr_addr_ff  <= '0;
      end else begin
         base_ff      <= base_in;
         next_free_ff <= next_free_in;
         clr_addr_ff  <= clr_addr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      cur_ff   <= cur_in;
      rd_ok_ff <= rd_ok_in;
      data_ff  <= data_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/page_table_mapper_core.sv @@
// Page table mapper: builds x86-64 four-level page tables in a pool of POOL_PAGES
// table pages held in one internal table memory (POOL_PAGES x 512 entries of 64 bits
// plus a tag bit, page 0 is the root). After reset the block runs a clearing pass over
// the whole memory, one entry per cycle, with req_stall high; csr writes are taken at
// any time. One item is worked at a time, and the table memory allows one write and
// one read per cycle with a registered read, so each walked level takes a read state,
// then a check and update state. A map walks its levels and then writes the leaf, a
// read takes one read and check, the unused command code goes straight to the result,
// and a walk that stops early on an error goes to the result at once; the next item
// is taken in the cycle after the result is registered, also while that result waits
// on rsp_stall.
// depends on ptm_pkg, ptm_ctrl, ptm_datapath
`default_nettype none

module page_table_mapper_core #(
   parameter int POOL_PAGES = ptm_pkg::POOL_PAGES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ptm_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ptm_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ptm_pkg::FRAME_W-1:0]  csr_data
);

   import ptm_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   // register writes never wait
   assign csr_ready = 1'b1;

   ptm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (dp_stat),
      .cmd       (ctl_cmd)
   );

   ptm_datapath #(
      .POOL_PAGES (POOL_PAGES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .csr_wr   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .cmd      (ctl_cmd),
      .stat     (dp_stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

@@ rtl/core/ptm_checker.sv @@
// ptm_checker: port-level assertions for page_table_mapper_core, attached by bind
// depends on ptm_pkg
`default_nettype none

module ptm_checker #(
   parameter int POOL_PAGES = ptm_pkg::POOL_PAGES_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input ptm_pkg::rsp_type  rsp_data
);

   import ptm_pkg::*;

   // clearing pass holds off items right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item input open right after reset");

   // one item at a time: busy after each accepted item
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   // a result held back keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   // pool exhaustion only with every page in use
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_POOL_FULL
      |-> rsp_data.tables_used == USED_W'(POOL_PAGES))
      else $error("pool exhausted with free pages left");

   // status is a defined code and, below 128 pages, the page count is nonzero
   a_rsp_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_DONE || rsp_data.status == STATUS_POOL_FULL
                     || rsp_data.status == STATUS_OUTSIDE)
                    && (POOL_PAGES >= 128 || rsp_data.tables_used != '0))
      else $error("bad status code or page count");

endmodule

bind page_table_mapper_core ptm_checker #(
   .POOL_PAGES (POOL_PAGES)
) u_ptm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
